FILE: hdl/assert_macros.svh
// Assertion macros shared by the scanner's RTL files.
// Needs nothing else; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("markup token scanner: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("markup token scanner: assertion failed");

`endif

FILE: hdl/mts_pkg.sv
// Shared types, codes and helper functions of the markup token scanner.
// Used by mts_scan_core, mts_token_fifo and markup_token_scanner.
`default_nettype none

package mts_pkg;

  // Positions, lines and columns count up to and saturate at 2**POS_BITS.
  localparam int POS_BITS = 20;
  localparam int POS_W    = POS_BITS + 1;

  // Up to four tokens leave the scanner for one byte.
  localparam int MAX_RES = 4;
  localparam int BN_W    = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  // Token kinds.
  localparam logic [4:0] K_END      = 5'd0;
  localparam logic [4:0] K_HASH     = 5'd1;
  localparam logic [4:0] K_LBRACE   = 5'd2;
  localparam logic [4:0] K_RBRACE   = 5'd3;
  localparam logic [4:0] K_COLON    = 5'd4;
  localparam logic [4:0] K_EQUALS   = 5'd5;
  localparam logic [4:0] K_SEMI     = 5'd6;
  localparam logic [4:0] K_DOT      = 5'd7;
  localparam logic [4:0] K_AMP      = 5'd8;
  localparam logic [4:0] K_PLUS     = 5'd9;
  localparam logic [4:0] K_MINUS    = 5'd10;
  localparam logic [4:0] K_SLASH    = 5'd11;
  localparam logic [4:0] K_PERCENT  = 5'd12;
  localparam logic [4:0] K_STAR     = 5'd13;
  localparam logic [4:0] K_DSTAR    = 5'd14;
  localparam logic [4:0] K_IDENT    = 5'd15;
  localparam logic [4:0] K_TEXT     = 5'd16;
  localparam logic [4:0] K_STYLE    = 5'd17;
  localparam logic [4:0] K_NUMBER   = 5'd18;
  localparam logic [4:0] K_STRING   = 5'd19;
  localparam logic [4:0] K_LCOMMENT = 5'd20;
  localparam logic [4:0] K_BCOMMENT = 5'd21;
  localparam logic [4:0] K_GCOMMENT = 5'd22;
  localparam logic [4:0] K_UNKNOWN  = 5'd23;

  // Characters with a meaning to the scanner.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_Y  = 8'h79;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_NUMDOT, M_FRAC, M_STRING,
    M_SLASH, M_LINE, M_BLOCK, M_HASH, M_GEN, M_STAR
  } mode_t;

  // Progress through the keywords "text" and "style".
  typedef enum logic [3:0] {
    KW_NONE, KW_T, KW_TE, KW_TEX, KW_TEXT,
    KW_S, KW_ST, KW_STY, KW_STYL, KW_STYLE
  } kw_t;

  typedef struct packed {
    logic [4:0]          kind;
    logic [POS_BITS-1:0] offset;
    logic [POS_W-1:0]    length;
    logic [POS_W-1:0]    line;
    logic [POS_W-1:0]    col;
    logic                run_end;
  } tok_t;

  // All tokens caused by one byte, in output order.
  typedef struct packed {
    logic [BN_W-1:0]             n;
    tok_t [MAX_RES-1:0]          tok;
  } burst_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {CH_SP, CH_CR, CH_TAB, CH_LF};
  endfunction

  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_COLON:  k = K_COLON;
      CH_EQUALS: k = K_EQUALS;
      CH_SEMI:   k = K_SEMI;
      CH_DOT:    k = K_DOT;
      CH_AMP:    k = K_AMP;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_PCT:    k = K_PERCENT;
      default:   k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic kw_t kw_step(input kw_t m, input logic [7:0] c);
    kw_t r;
    r = KW_NONE;
    case (m)
      KW_T:    if (c == CH_LOW_E) r = KW_TE;
      KW_TE:   if (c == CH_LOW_X) r = KW_TEX;
      KW_TEX:  if (c == CH_LOW_T) r = KW_TEXT;
      KW_S:    if (c == CH_LOW_T) r = KW_ST;
      KW_ST:   if (c == CH_LOW_Y) r = KW_STY;
      KW_STY:  if (c == CH_LOW_L) r = KW_STYL;
      KW_STYL: if (c == CH_LOW_E) r = KW_STYLE;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] ident_kind(input kw_t m);
    logic [4:0] k;
    case (m)
      KW_TEXT:  k = K_TEXT;
      KW_STYLE: k = K_STYLE;
      default:  k = K_IDENT;
    endcase
    return k;
  endfunction

  // Builds a token from its first position and the position after it.
  function automatic tok_t mk_tok(input logic [4:0] kind, input logic [POS_W-1:0] t_beg,
                                  input logic [POS_W:0] t_stop,
                                  input logic [POS_W-1:0] ln,
                                  input logic [POS_W-1:0] cl);
    tok_t t;
    logic [POS_W:0] beg_x;
    beg_x     = {1'b0, t_beg};
    t.kind    = kind;
    t.offset  = t_beg[POS_BITS] ? {POS_BITS{1'b1}} : t_beg[POS_BITS-1:0];
    t.length  = (t_stop >= beg_x) ? POS_W'(t_stop - beg_x) : '0;
    t.line    = ln;
    t.col     = cl;
    t.run_end = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/markup_token_scanner.sv
// Markup token scanner: one source byte in, tokens out.
// Input channel: in_valid/in_ready with in_char_byte and in_final_char; a byte
// is taken on a clock edge where both are high.
// Result channel: out_valid/out_ready with the token fields; one token per
// transfer, in source order.
// Latency: a byte's tokens enter the result queue at its transfer; when the queue
// was empty, the first of them is offered in the cycle after that byte's transfer.
// Throughput: one byte per cycle while the result queue has room. A byte
// causes zero to four tokens and the queue gives one token per transfer, so
// bytes that close several tokens can fill the queue and hold the input.
// in_ready depends only on the registered queue fill (at most four tokens held).
// The final byte flushes the pending token, adds an end token with out_run_end
// set, and returns the scanner to offset 0, line 1, column 1.
// Reset (rst_n low, synchronous) empties the queue and clears the scanner.
// When the receiver stalls, the queue fills and in_ready drops; nothing is lost.
// Depends on mts_pkg, mts_scan_core and mts_token_fifo.
`default_nettype none

module markup_token_scanner (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_char_byte,
  input  wire logic                          in_final_char,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [4:0]                         out_token_kind,
  output logic [mts_pkg::POS_BITS-1:0]       out_start_offset,
  output logic [mts_pkg::POS_W-1:0]          out_token_length,
  output logic [mts_pkg::POS_W-1:0]          out_start_line,
  output logic [mts_pkg::POS_W-1:0]          out_start_column,
  output logic                               out_run_end
);
  import mts_pkg::*;

  logic   fire;
  burst_t burst;
  tok_t   head;

  assign fire = in_valid && in_ready;

  mts_scan_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .char_byte  (in_char_byte),
    .final_char (in_final_char),
    .burst      (burst)
  );

  mts_token_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fire),
    .burst    (burst),
    .space_ok (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_tok   (head)
  );

  assign out_token_kind   = head.kind;
  assign out_start_offset = head.offset;
  assign out_token_length = head.length;
  assign out_start_line   = head.line;
  assign out_start_column = head.col;
  assign out_run_end      = head.run_end;

endmodule

`default_nettype wire

FILE: hdl/mts_scan_core.sv
// Scanner state and the single-pass token logic for one source byte.
// Depends on mts_pkg and assert_macros.svh.
`default_nettype none

module mts_scan_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      char_byte,
  input  wire logic            final_char,
  output mts_pkg::burst_t      burst
);
  import mts_pkg::*;
  `include "assert_macros.svh"

  mode_t            mode_r, mode_nxt;
  kw_t              kw_r, kw_nxt;
  logic [POS_W-1:0] tb_r, tb_nxt, tbl_r, tbl_nxt, tbc_r, tbc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [7:0]       quote_r, quote_nxt;
  logic             star_r, star_nxt;

  logic [POS_W-1:0] pos_a, line_a, col_a, dot_col, fdot_col;
  logic [POS_W:0]   p0, p1, pm1, e0, em1;
  logic             st_do;
  mode_t            mode_s;
  tok_t             cand [6];
  logic [5:0]       cand_v;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    mode_nxt  = mode_r;
    kw_nxt    = kw_r;
    tb_nxt    = tb_r;
    tbl_nxt   = tbl_r;
    tbc_nxt   = tbc_r;
    quote_nxt = quote_r;
    star_nxt  = star_r;
    st_do     = 1'b0;
    cand_v    = '0;
    for (int i = 0; i < 6; i++) begin
      cand[i] = '0;
    end

    p0      = {1'b0, pos_r};
    p1      = p0 + (POS_W + 1)'(1);
    pm1     = p0 - (POS_W + 1)'(1);
    dot_col = (col_r > POS_W'(1)) ? col_r - POS_W'(1) : POS_W'(1);

    // Slot 0 closes the pending token, slot 1 is the dot split off a number.
    case (mode_r)
      M_IDENT: begin
        if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == CH_US ||
            char_byte == CH_MINUS) begin
          kw_nxt = kw_step(kw_r, char_byte);
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(ident_kind(kw_r), tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_NUM: begin
        if (char_byte == CH_DOT) begin
          mode_nxt = M_NUMDOT;
        end else if (!is_digit(char_byte)) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_NUMBER, tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (is_digit(char_byte)) begin
          mode_nxt = M_FRAC;
        end else begin
          cand_v[1:0] = 2'b11;
          cand[0]     = mk_tok(K_NUMBER, tb_r, pm1, tbl_r, tbc_r);
          cand[1]     = mk_tok(K_DOT, POS_W'(pm1), p0, line_r, dot_col);
          st_do       = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(char_byte)) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_NUMBER, tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_STRING: begin
        if (char_byte == quote_r) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_STRING, tb_r, p1, tbl_r, tbc_r);
          mode_nxt  = M_IDLE;
        end
      end
      M_SLASH: begin
        if (char_byte == CH_SLASH) begin
          mode_nxt = M_LINE;
        end else if (char_byte == CH_STAR) begin
          mode_nxt = M_BLOCK;
          star_nxt = 1'b0;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_SLASH, tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_LINE, M_GEN: begin
        if (char_byte == CH_LF) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok((mode_r == M_LINE) ? K_LCOMMENT : K_GCOMMENT,
                             tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_BLOCK: begin
        // The star of the opening pair was cleared on entry, so it cannot close.
        if (star_r && char_byte == CH_SLASH) begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_BCOMMENT, tb_r, p1, tbl_r, tbc_r);
          mode_nxt  = M_IDLE;
          star_nxt  = 1'b0;
        end else begin
          star_nxt = (char_byte == CH_STAR);
        end
      end
      M_HASH: begin
        if (char_byte == CH_SP) begin
          mode_nxt = M_GEN;
        end else begin
          cand_v[0] = 1'b1;
          cand[0]   = mk_tok(K_HASH, tb_r, p0, tbl_r, tbc_r);
          st_do     = 1'b1;
        end
      end
      M_STAR: begin
        cand_v[0] = 1'b1;
        if (char_byte == CH_STAR) begin
          cand[0]  = mk_tok(K_DSTAR, tb_r, p1, tbl_r, tbc_r);
          mode_nxt = M_IDLE;
        end else begin
          cand[0] = mk_tok(K_STAR, tb_r, p0, tbl_r, tbc_r);
          st_do   = 1'b1;
        end
      end
      default: begin
        st_do = 1'b1;
      end
    endcase

    // The byte that ended a token, or any byte between tokens, may begin one.
    if (st_do) begin
      mode_nxt = M_IDLE;
      if (!is_space(char_byte)) begin
        tb_nxt  = pos_r;
        tbl_nxt = line_r;
        tbc_nxt = col_r;
        if (char_byte == CH_SLASH) begin
          mode_nxt = M_SLASH;
        end else if (char_byte == CH_HASH) begin
          mode_nxt = M_HASH;
        end else if (char_byte == CH_STAR) begin
          mode_nxt = M_STAR;
        end else if (char_byte == CH_DQUOTE || char_byte == CH_SQUOTE) begin
          quote_nxt = char_byte;
          mode_nxt  = M_STRING;
        end else if (is_alpha(char_byte) || char_byte == CH_US) begin
          kw_nxt   = (char_byte == CH_LOW_T) ? KW_T :
                     (char_byte == CH_LOW_S) ? KW_S : KW_NONE;
          mode_nxt = M_IDENT;
        end else if (is_digit(char_byte)) begin
          mode_nxt = M_NUM;
        end else begin
          cand_v[2] = 1'b1;
          cand[2]   = mk_tok(punct_kind(char_byte), pos_r, p1, line_r, col_r);
        end
      end
    end

    // Positions after this byte, saturating at 2**POS_BITS.
    pos_a = pos_r[POS_BITS] ? pos_r : pos_r + POS_W'(1);
    if (char_byte == CH_LF) begin
      line_a = line_r[POS_BITS] ? line_r : line_r + POS_W'(1);
      col_a  = POS_W'(1);
    end else begin
      line_a = line_r;
      col_a  = col_r[POS_BITS] ? col_r : col_r + POS_W'(1);
    end

    mode_s   = mode_nxt;
    e0       = {1'b0, pos_a};
    em1      = e0 - (POS_W + 1)'(1);
    fdot_col = (col_a > POS_W'(1)) ? col_a - POS_W'(1) : POS_W'(1);

    pos_nxt  = pos_a;
    line_nxt = line_a;
    col_nxt  = col_a;

    // On the final byte the pending token is flushed, an end token follows and
    // the scanner goes back to its reset state.
    if (final_char) begin
      cand_v[3] = (mode_s != M_IDLE);
      case (mode_s)
        M_IDENT:         cand[3] = mk_tok(ident_kind(kw_nxt), tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_NUM, M_FRAC:   cand[3] = mk_tok(K_NUMBER, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_NUMDOT: begin
          cand[3]   = mk_tok(K_NUMBER, tb_nxt, em1, tbl_nxt, tbc_nxt);
          cand_v[4] = 1'b1;
          cand[4]   = mk_tok(K_DOT, POS_W'(em1), e0, line_a, fdot_col);
        end
        M_STRING, M_BLOCK: cand[3] = mk_tok(K_UNKNOWN, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_SLASH:         cand[3] = mk_tok(K_SLASH, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_LINE:          cand[3] = mk_tok(K_LCOMMENT, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_GEN:           cand[3] = mk_tok(K_GCOMMENT, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_HASH:          cand[3] = mk_tok(K_HASH, tb_nxt, e0, tbl_nxt, tbc_nxt);
        M_STAR:          cand[3] = mk_tok(K_STAR, tb_nxt, e0, tbl_nxt, tbc_nxt);
        default:         cand[3] = '0;
      endcase
      cand_v[5]       = 1'b1;
      cand[5]         = mk_tok(K_END, pos_a, e0, line_a, col_a);
      cand[5].run_end = 1'b1;

      mode_nxt  = M_IDLE;
      kw_nxt    = KW_NONE;
      tb_nxt    = '0;
      tbl_nxt   = POS_W'(1);
      tbc_nxt   = POS_W'(1);
      pos_nxt   = '0;
      line_nxt  = POS_W'(1);
      col_nxt   = POS_W'(1);
      quote_nxt = '0;
      star_nxt  = 1'b0;
    end
  end

  // Pack the candidates, in order, into the first slots of the burst.
  always_comb begin
    burst = '0;
    for (int i = 0; i < 6; i++) begin
      if (cand_v[i] && burst.n < BN_W'(MAX_RES)) begin
        burst.tok[burst.n[IDX_W-1:0]] = cand[i];
        burst.n = burst.n + BN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      kw_r    <= KW_NONE;
      tb_r    <= '0;
      tbl_r   <= POS_W'(1);
      tbc_r   <= POS_W'(1);
      pos_r   <= '0;
      line_r  <= POS_W'(1);
      col_r   <= POS_W'(1);
      quote_r <= '0;
      star_r  <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      kw_r    <= kw_nxt;
      tb_r    <= tb_nxt;
      tbl_r   <= tbl_nxt;
      tbc_r   <= tbc_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      quote_r <= quote_nxt;
      star_r  <= star_nxt;
    end
  end

  assign last_idx = IDX_W'(burst.n - BN_W'(1));

  `MTS_ASSERT(a_final_ends_run, clk, rst_n, fire && final_char,
              burst.n != '0 && burst.tok[last_idx].run_end)
  `MTS_ASSERT_NXT(a_final_resets, clk, rst_n, fire && final_char,
                  pos_r == '0 && line_r == POS_W'(1) && mode_r == M_IDLE)

endmodule

`default_nettype wire

FILE: hdl/mts_token_fifo.sv
// Result queue: takes a burst of up to four tokens per cycle, gives one while the reader is ready.
// Depends on mts_pkg and assert_macros.svh.
`default_nettype none

module mts_token_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire mts_pkg::burst_t burst,
  output logic                 space_ok,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output mts_pkg::tok_t        rd_tok
);
  import mts_pkg::*;
  `include "assert_macros.svh"

  tok_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FCNT_W-1:0] count_r, count_nxt;
  logic [BN_W-1:0]   wr_n;
  logic              pop;

  assign wr_n     = wr_en ? burst.n : '0;
  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (count_r != '0);
  assign rd_tok   = mem[rd_ptr_r];
  // Room for a whole burst, judged on the registered fill alone.
  assign space_ok = (count_r <= FCNT_W'(FIFO_DEPTH - MAX_RES));

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(wr_n);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + FCNT_W'(wr_n) - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (BN_W'(i) < wr_n) begin
        mem[wr_ptr_r + PTR_W'(i)] <= burst.tok[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `MTS_ASSERT(a_fill_bound, clk, rst_n, 1'b1, count_r <= FCNT_W'(FIFO_DEPTH))
  `MTS_ASSERT(a_write_has_room, clk, rst_n, wr_n != '0, space_ok)

endmodule

`default_nettype wire

FILE: sim/markup_token_scanner_tb.sv
// Self-checking testbench for markup_token_scanner: feeds source text as byte
// transfers and checks every token against a scanner model kept in the bench.
// Depends on mts_pkg and the scanner RTL only.
`timescale 1ns / 100ps

module markup_token_scanner_tb;
  import mts_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 180;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(1) << POS_BITS;

  localparam logic [7:0] TEXT_CHARS  [0:3] = '{CH_LOW_T, CH_LOW_E, CH_LOW_X, CH_LOW_T};
  localparam logic [7:0] STYLE_CHARS [0:4] = '{CH_LOW_S, CH_LOW_T, CH_LOW_Y, CH_LOW_L,
                                               CH_LOW_E};

  localparam string LEAD_CH  = "abcstxyzABCZ_";
  localparam string WORD_CH  = "etxylsab09_-Z";
  localparam string DIGIT_CH = "0123456789";
  localparam string BODY_CH  = "ab 9*/#\n'\"{";
  localparam string PUNCT_CH = "{}:=;.&+-%*/";
  localparam string SPACE_CH = " \t\015\n";

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [7:0]          in_char_byte;
  logic                in_final_char;
  logic                out_valid;
  logic                out_ready;
  logic [4:0]          out_token_kind;
  logic [POS_BITS-1:0] out_start_offset;
  logic [POS_W-1:0]    out_token_length;
  logic [POS_W-1:0]    out_start_line;
  logic [POS_W-1:0]    out_start_column;
  logic                out_run_end;

  logic [7:0] src_q[$];
  bit         calm;
  int         gap_pct;
  int         quiet_cycles;

  // Scanner model: tracks the scan state byte by byte and queues the tokens
  // each byte should release, in source order.
  class token_scoreboard;
    mode_t            mode;
    kw_t              kw;
    logic [POS_W-1:0] tok_off, tok_line, tok_col;
    logic [POS_W-1:0] pos, line_no, col_no;
    logic [7:0]       quote;
    logic             star;
    tok_t             expect_q[$];
    int               mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      mode     = M_IDLE;
      kw       = KW_NONE;
      tok_off  = '0;
      tok_line = POS_W'(1);
      tok_col  = POS_W'(1);
      pos      = '0;
      line_no  = POS_W'(1);
      col_no   = POS_W'(1);
      quote    = '0;
      star     = 1'b0;
    endfunction

    function logic letter_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function logic digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic blank_ch(logic [7:0] c);
      return c == CH_SP || c == CH_CR || c == CH_TAB || c == CH_LF;
    endfunction

    function void push_token(logic [4:0] kind, logic [POS_W-1:0] first,
                             logic [POS_W-1:0] stop, logic [POS_W-1:0] ln,
                             logic [POS_W-1:0] cl);
      tok_t t;
      t.kind    = kind;
      t.offset  = (first >= POS_MAX - 1) ? {POS_BITS{1'b1}} : first[POS_BITS-1:0];
      t.length  = (stop >= first) ? stop - first : '0;
      t.line    = ln;
      t.col     = cl;
      t.run_end = 1'b0;
      expect_q.insert(expect_q.size(), t);
    endfunction

    function void pending_token(logic [4:0] kind, logic [POS_W-1:0] stop);
      push_token(kind, tok_off, stop, tok_line, tok_col);
    endfunction

    function void word_token(logic [POS_W-1:0] stop);
      logic [4:0] k;
      k = K_IDENT;
      if (kw == KW_TEXT) k = K_TEXT;
      else if (kw == KW_STYLE) k = K_STYLE;
      pending_token(k, stop);
    endfunction

    // A held dot after digits turned out not to start a fraction: the number
    // ends before it and the dot becomes a token of its own.
    function void number_then_dot();
      logic [POS_W-1:0] dot_col;
      dot_col = (col_no > 1) ? col_no - 1 : POS_W'(1);
      pending_token(K_NUMBER, pos - 1);
      push_token(K_DOT, pos - 1, pos, line_no, dot_col);
    endfunction

    function void open_token(logic [7:0] c);
      logic [4:0] k;
      mode = M_IDLE;
      if (blank_ch(c)) return;
      tok_off  = pos;
      tok_line = line_no;
      tok_col  = col_no;
      if (c == CH_SLASH) begin
        mode = M_SLASH;
      end else if (c == CH_HASH) begin
        mode = M_HASH;
      end else if (c == CH_STAR) begin
        mode = M_STAR;
      end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        quote = c;
        mode  = M_STRING;
      end else if (letter_ch(c) || c == CH_US) begin
        kw   = (c == CH_LOW_T) ? KW_T : (c == CH_LOW_S) ? KW_S : KW_NONE;
        mode = M_IDENT;
      end else if (digit_ch(c)) begin
        mode = M_NUM;
      end else begin
        case (c)
          CH_LBRACE: k = K_LBRACE;
          CH_RBRACE: k = K_RBRACE;
          CH_COLON:  k = K_COLON;
          CH_EQUALS: k = K_EQUALS;
          CH_SEMI:   k = K_SEMI;
          CH_DOT:    k = K_DOT;
          CH_AMP:    k = K_AMP;
          CH_PLUS:   k = K_PLUS;
          CH_MINUS:  k = K_MINUS;
          CH_PCT:    k = K_PERCENT;
          default:   k = K_UNKNOWN;
        endcase
        pending_token(k, pos + 1);
      end
    endfunction

    function void take_char(logic [7:0] c);
      int m;
      case (mode)
        M_IDENT: begin
          if (letter_ch(c) || digit_ch(c) || c == CH_US || c == CH_MINUS) begin
            m = int'(kw);
            if (m >= int'(KW_T) && m < int'(KW_TEXT) && c == TEXT_CHARS[m])
              kw = kw_t'(m + 1);
            else if (m >= int'(KW_S) && m < int'(KW_STYLE) &&
                     c == STYLE_CHARS[m - int'(KW_S) + 1])
              kw = kw_t'(m + 1);
            else
              kw = KW_NONE;
          end else begin
            word_token(pos);
            open_token(c);
          end
        end
        M_NUM: begin
          if (c == CH_DOT) begin
            mode = M_NUMDOT;
          end else if (!digit_ch(c)) begin
            pending_token(K_NUMBER, pos);
            open_token(c);
          end
        end
        M_NUMDOT: begin
          if (digit_ch(c)) begin
            mode = M_FRAC;
          end else begin
            number_then_dot();
            open_token(c);
          end
        end
        M_FRAC: begin
          if (!digit_ch(c)) begin
            pending_token(K_NUMBER, pos);
            open_token(c);
          end
        end
        M_STRING: begin
          if (c == quote) begin
            pending_token(K_STRING, pos + 1);
            mode = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode = M_LINE;
          end else if (c == CH_STAR) begin
            mode = M_BLOCK;
            star = 1'b0;
          end else begin
            pending_token(K_SLASH, pos);
            open_token(c);
          end
        end
        M_LINE, M_GEN: begin
          if (c == CH_LF) begin
            pending_token(mode == M_LINE ? K_LCOMMENT : K_GCOMMENT, pos);
            open_token(c);
          end
        end
        M_BLOCK: begin
          // The star of the opening pair was never recorded, so it cannot close.
          if (star && c == CH_SLASH) begin
            pending_token(K_BCOMMENT, pos + 1);
            mode = M_IDLE;
            star = 1'b0;
          end else begin
            star = (c == CH_STAR);
          end
        end
        M_HASH: begin
          if (c == CH_SP) begin
            mode = M_GEN;
          end else begin
            pending_token(K_HASH, pos);
            open_token(c);
          end
        end
        M_STAR: begin
          if (c == CH_STAR) begin
            pending_token(K_DSTAR, pos + 1);
            mode = M_IDLE;
          end else begin
            pending_token(K_STAR, pos);
            open_token(c);
          end
        end
        default: open_token(c);
      endcase
      if (pos < POS_MAX) pos = pos + 1;
      if (c == CH_LF) begin
        if (line_no < POS_MAX) line_no = line_no + 1;
        col_no = POS_W'(1);
      end else if (col_no < POS_MAX) begin
        col_no = col_no + 1;
      end
    endfunction

    function void end_run();
      tok_t t;
      case (mode)
        M_IDENT:          word_token(pos);
        M_NUM, M_FRAC:    pending_token(K_NUMBER, pos);
        M_NUMDOT:         number_then_dot();
        M_STRING, M_BLOCK: pending_token(K_UNKNOWN, pos);
        M_SLASH:          pending_token(K_SLASH, pos);
        M_LINE:           pending_token(K_LCOMMENT, pos);
        M_GEN:            pending_token(K_GCOMMENT, pos);
        M_HASH:           pending_token(K_HASH, pos);
        M_STAR:           pending_token(K_STAR, pos);
        default:          ;
      endcase
      push_token(K_END, pos, pos, line_no, col_no);
      t = expect_q.pop_back();
      t.run_end = 1'b1;
      expect_q.insert(expect_q.size(), t);
      clear();
    endfunction

    function void note_byte(logic [7:0] c, logic last);
      take_char(c);
      if (last) end_run();
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (expect_q.size() == 0) begin
        $error("unexpected token: kind %0d at offset %0d", got.kind, got.offset);
        mismatches++;
        return;
      end
      want = expect_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.offset !== want.offset) begin
        $error("start_offset: expected %0d, got %0d", want.offset, got.offset);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $error("token_length: expected %0d, got %0d", want.length, got.length);
        mismatches++;
      end
      if (got.line !== want.line) begin
        $error("start_line: expected %0d, got %0d", want.line, got.line);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("start_column: expected %0d, got %0d", want.col, got.col);
        mismatches++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
        mismatches++;
      end
    endfunction
  endclass

  token_scoreboard sb;

  markup_token_scanner uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_byte     (in_char_byte),
    .in_final_char    (in_final_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_start_line   (out_start_line),
    .out_start_column (out_start_column),
    .out_run_end      (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Both channels are sampled at the edge, before any of its updates land.
  always @(posedge clk) begin : port_monitor
    tok_t got;
    if (rst_n && in_valid && in_ready) sb.note_byte(in_char_byte, in_final_char);
    if (rst_n && out_valid && out_ready) begin
      got.kind    = out_token_kind;
      got.offset  = out_start_offset;
      got.length  = out_token_length;
      got.line    = out_start_line;
      got.col     = out_start_column;
      got.run_end = out_run_end;
      sb.check_token(got);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("markup_token_scanner regression: fail");
      $finish;
    end
  end

  // Receiver: ready stretches of varying length broken by stall bursts.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  function automatic void add_byte(logic [7:0] b);
    src_q.insert(src_q.size(), b);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // One source run made mostly of well-formed tokens with random content,
  // salted with stray bytes; now and then a run of pure noise.
  function automatic void build_run();
    int         target;
    logic [7:0] q;
    target = $urandom_range(4, 40);
    if ($urandom_range(0, 9) == 0) begin
      repeat (target) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    while (src_q.size() < target) begin
      case ($urandom_range(0, 9))
        0: begin
          add_byte(pick(LEAD_CH));
          repeat ($urandom_range(0, 5)) add_byte(pick(WORD_CH));
        end
        1: begin
          case ($urandom_range(0, 5))
            0: push_text("text");
            1: push_text("style");
            2: push_text("tex");
            3: push_text("styl");
            4: push_text("texts");
            default: push_text("style-2");
          endcase
        end
        2: begin
          repeat ($urandom_range(1, 4)) add_byte(pick(DIGIT_CH));
          if ($urandom_range(0, 1)) begin
            add_byte(CH_DOT);
            repeat ($urandom_range(0, 3)) add_byte(pick(DIGIT_CH));
          end
        end
        3: begin
          q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          add_byte(q);
          repeat ($urandom_range(0, 6)) add_byte(pick(BODY_CH));
          if ($urandom_range(0, 7) != 0) add_byte(q);
        end
        4: begin
          push_text("//");
          repeat ($urandom_range(0, 6)) add_byte(pick(BODY_CH));
          add_byte(CH_LF);
        end
        5: begin
          push_text("/*");
          repeat ($urandom_range(0, 6)) add_byte(pick(BODY_CH));
          if ($urandom_range(0, 7) != 0) push_text("*/");
        end
        6: begin
          add_byte(CH_HASH);
          if ($urandom_range(0, 1)) begin
            add_byte(CH_SP);
            repeat ($urandom_range(0, 6)) add_byte(pick(BODY_CH));
            add_byte(CH_LF);
          end
        end
        7: begin
          if ($urandom_range(0, 4) == 0) push_text("**");
          else add_byte(pick(PUNCT_CH));
        end
        8: repeat ($urandom_range(1, 3)) add_byte(pick(SPACE_CH));
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 1)) add_byte(pick(SPACE_CH));
    end
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_byte  <= c;
    in_final_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Sends the queued run with the final flag on its last byte.
  task automatic send_run();
    for (int i = 0; i < src_q.size(); i++) send_byte(src_q[i], i == src_q.size() - 1);
    src_q.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expect_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    int runs;
    sb            = new();
    calm          = 1'b0;
    gap_pct       = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_char_byte  <= '0;
    in_final_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Keyword, then a number whose dot is followed by the final semicolon:
    // that last byte releases four tokens at once.
    push_text("text=1.;");
    send_run();
    // Block comment that the opening star cannot close, spanning a line, then
    // a string left open at the final byte.
    push_text("/*/\n*/'\n");
    send_run();
    // NUL and 0xFF, a generator comment, an empty line comment, a double star
    // and a lone star and slash flushed by the final byte.
    add_byte(8'h00);
    add_byte(8'hFF);
    push_text("# g\n//\n***/");
    send_run();
    drain();

    sent = 0;
    runs = 0;
    while (sent < RANDOM_BYTES) begin
      build_run();
      if (sent >= RANDOM_BYTES * 3 / 4) calm = 1'b1;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      sent += src_q.size();
      send_run();
      runs++;
      if (runs == 4) drain();
    end
    drain();
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0 && sb.expect_q.size() == 0) begin
      $display("markup_token_scanner regression: pass");
    end else begin
      $display("markup_token_scanner regression: fail");
    end
    $finish;
  end

endmodule
